// ----- rtl/vdl_pkg.sv -----
// vdl_pkg: shared widths, codes and types of the vertex directional lighting block
// no dependencies; used by the interfaces, the top level, vdl_mul and vdl_seq
package vdl_pkg;

	// light table size that the top level defaults to (supported range 1 to 8, the slots that SLOT_W can address)
	localparam int MAX_LIGHTS_DEF = 8;

	// item field widths
	localparam int VEC_W   = 16;
	localparam int COLOR_W = 8;
	localparam int SLOT_W  = 3;
	localparam int COUNT_W = 4;

	// fixed-point arithmetic
	localparam int FRAC_W = 14;            // Q1.14 vectors, Q.14 shade
	localparam int DOT_W  = 33;            // sum of three Q2.28 products
	localparam int D_W    = 18;            // positive dot product after >> 14
	localparam int MUL_W  = 19;            // shared multiplier operand width
	localparam int PROD_W = 2 * MUL_W;
	localparam int ACC_W  = 32;            // holds ambient plus 16 full lights

	// light table entry: direction x, y, z then color r, g, b
	localparam int ENTRY_W = 3 * VEC_W + 3 * COLOR_W;

	// configuration port
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 2;

	localparam logic [REG_IDX_W-1:0] REG_LIGHT_COUNT   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_AMBIENT_RED   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_AMBIENT_GREEN = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_AMBIENT_BLUE  = 2'd3;

	// request function codes
	localparam logic FUNC_VERTEX      = 1'b0;
	localparam logic FUNC_LIGHT_WRITE = 1'b1;

	typedef struct packed {
		logic [COUNT_W-1:0] light_count;
		logic [COLOR_W-1:0] ambient_red;
		logic [COLOR_W-1:0] ambient_green;
		logic [COLOR_W-1:0] ambient_blue;
	} cfg_t;

	typedef struct packed {
		logic [VEC_W-1:0]   dir_x;
		logic [VEC_W-1:0]   dir_y;
		logic [VEC_W-1:0]   dir_z;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} light_entry_t;

	typedef struct packed {
		logic [MUL_W-1:0] a;
		logic [MUL_W-1:0] b;
	} mul_req_t;

endpackage

// ----- rtl/vdl_if.sv -----
// vdl_in_if / vdl_out_if: valid-ready channels for requests and lit colors
// depends on vdl_pkg
interface vdl_in_if import vdl_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      func;
	logic signed [VEC_W-1:0]   vec_x;
	logic signed [VEC_W-1:0]   vec_y;
	logic signed [VEC_W-1:0]   vec_z;
	logic [SLOT_W-1:0]         light_slot;
	logic [COLOR_W-1:0]        light_red;
	logic [COLOR_W-1:0]        light_green;
	logic [COLOR_W-1:0]        light_blue;

	modport source (
		output valid, func, vec_x, vec_y, vec_z, light_slot, light_red, light_green,
			light_blue,
		input  ready
	);
	modport sink (
		input  valid, func, vec_x, vec_y, vec_z, light_slot, light_red, light_green,
			light_blue,
		output ready
	);
endinterface

interface vdl_out_if import vdl_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] lit_red;
	logic [COLOR_W-1:0] lit_green;
	logic [COLOR_W-1:0] lit_blue;

	modport source (output valid, lit_red, lit_green, lit_blue, input ready);
	modport sink (input valid, lit_red, lit_green, lit_blue, output ready);
endinterface

// ----- rtl/vertex_directional_lighting.sv -----
// vertex_directional_lighting: per-vertex lambert diffuse lighting, top level
// depends on vdl_pkg, vdl_if, vdl_ram, vdl_mul and vdl_seq
//
//   channel   dir   handshake              carries
//   in_ch     in    valid/ready            vertex normal or light table write
//   out_ch    out   valid/ready            lit color, one per vertex request
//   apb       in    psel/penable/pwrite    light_count and ambient levels
//
// a light table write request gives no result
// a vertex request runs, for each light in use, one table read and eight
// steps around the single shared multiplier, which does three dot terms
// and three color scalings per light
// the block takes one request at a time; a finished color waits in the output
// register and holds the sequencer only when the next one is done before it
// is taken
// reset clears control and configuration; the light table is not cleared
module vertex_directional_lighting import vdl_pkg::*; #(
	parameter int MAX_LIGHTS = MAX_LIGHTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	vdl_in_if.sink                in_ch,
	vdl_out_if.source             out_ch,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int AW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;

	cfg_t                cfg_q;
	logic                cfg_write;
	logic [REG_IDX_W-1:0] reg_idx;

	mul_req_t            mul_req;
	logic [PROD_W-1:0]   product;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [AW-1:0]       ram_raddr;
	logic [ENTRY_W-1:0]  ram_wdata;
	logic [ENTRY_W-1:0]  ram_rdata;

	// configuration registers, written in the apb access phase
	assign pready    = 1'b1;
	assign reg_idx   = paddr[APB_ADDR_W-1:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_LIGHT_COUNT:   cfg_q.light_count   <= pwdata[COUNT_W-1:0];
				REG_AMBIENT_RED:   cfg_q.ambient_red   <= pwdata[COLOR_W-1:0];
				REG_AMBIENT_GREEN: cfg_q.ambient_green <= pwdata[COLOR_W-1:0];
				REG_AMBIENT_BLUE:  cfg_q.ambient_blue  <= pwdata[COLOR_W-1:0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			REG_LIGHT_COUNT:   prdata = APB_DATA_W'(cfg_q.light_count);
			REG_AMBIENT_RED:   prdata = APB_DATA_W'(cfg_q.ambient_red);
			REG_AMBIENT_GREEN: prdata = APB_DATA_W'(cfg_q.ambient_green);
			REG_AMBIENT_BLUE:  prdata = APB_DATA_W'(cfg_q.ambient_blue);
			default:           prdata = '0;
		endcase
	end

	// light table: direction and color per slot
	vdl_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_LIGHTS)
	) u_light_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// one multiplier shared by the dot product and the color scaling
	vdl_mul u_mul (
		.clk     (clk),
		.req     (mul_req),
		.product (product)
	);

	vdl_seq #(
		.MAX_LIGHTS (MAX_LIGHTS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg       (cfg_q),
		.mul_req   (mul_req),
		.product   (product),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

`ifndef NO_ASSERTIONS
	// a vertex request occupies the sequencer
	a_vertex_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && (in_ch.func == FUNC_VERTEX)) |=> !in_ch.ready)
		else $error("block still ready after a vertex request");

	// a light table write never stalls the next request
	a_write_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && (in_ch.func == FUNC_LIGHT_WRITE)) |=> in_ch.ready)
		else $error("light table write blocked the input");

	// a new color only comes out of the finish step, never while idle
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> !$past(in_ch.ready))
		else $error("result appeared without a vertex in progress");
`endif

endmodule

// ----- rtl/vdl_ram.sv -----
// vdl_ram: generic single-write, single-read ram with registered read data
// no dependencies
module vdl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/vdl_mul.sv -----
// vdl_mul: shared signed multiplier with a registered product
// depends on vdl_pkg
module vdl_mul import vdl_pkg::*; (
	input  logic              clk,
	input  mul_req_t          req,
	output logic [PROD_W-1:0] product
);

	logic signed [PROD_W-1:0] product_q;

	always_ff @(posedge clk) begin
		product_q <= $signed(req.a) * $signed(req.b);
	end

	assign product = product_q;

endmodule

// ----- rtl/vdl_seq.sv -----
// vdl_seq: sequencer, light table access and channel accumulators
// depends on vdl_pkg and the vdl_in_if / vdl_out_if interfaces
module vdl_seq import vdl_pkg::*; #(
	parameter int MAX_LIGHTS = MAX_LIGHTS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	vdl_in_if.sink                 in_ch,
	vdl_out_if.source              out_ch,
	input  cfg_t                   cfg,
	output mul_req_t               mul_req,
	input  logic [PROD_W-1:0]      product,
	output logic                   ram_we,
	output logic [((MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1)-1:0] ram_waddr,
	output logic [ENTRY_W-1:0]     ram_wdata,
	output logic [((MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1)-1:0] ram_raddr,
	input  logic [ENTRY_W-1:0]     ram_rdata
);

	localparam int AW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
	localparam int CW = $clog2(MAX_LIGHTS + 1);

	// steps of one light: three dot terms, then three color scalings
	localparam logic [2:0] STEP_MUL_X   = 3'd0;
	localparam logic [2:0] STEP_MUL_Y   = 3'd1;
	localparam logic [2:0] STEP_MUL_Z   = 3'd2;
	localparam logic [2:0] STEP_DOT_END = 3'd3;
	localparam logic [2:0] STEP_MUL_R   = 3'd4;
	localparam logic [2:0] STEP_MUL_G   = 3'd5;
	localparam logic [2:0] STEP_MUL_B   = 3'd6;
	localparam logic [2:0] STEP_LAST    = 3'd7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_STEP,
		ST_FINISH
	} state_t;

	state_t                    state_q;
	logic [2:0]                step_q;
	logic [CW-1:0]             light_num_q;
	logic [CW-1:0]             count_q;
	logic [VEC_W-1:0]          nx_q, ny_q, nz_q;
	logic signed [DOT_W-1:0]   dot_q;
	logic [ACC_W-1:0]          acc_r_q, acc_g_q, acc_b_q;
	logic                      out_valid_q;
	logic [COLOR_W-1:0]        lit_r_q, lit_g_q, lit_b_q;

	light_entry_t              entry;
	logic                      accept;
	logic                      dot_pos;
	logic [D_W-1:0]            shade;
	logic [CW-1:0]             eff_count;
	logic [CW-1:0]             next_num;
	logic signed [DOT_W-1:0]   dot_term;
	logic [ACC_W-1:0]          color_term;

	function automatic logic [COLOR_W-1:0] clamp_channel(input logic [ACC_W-1:0] acc);
		logic [ACC_W-FRAC_W-1:0] whole;
		whole = acc[ACC_W-1:FRAC_W];
		clamp_channel = (whole > (ACC_W-FRAC_W)'({COLOR_W{1'b1}})) ? {COLOR_W{1'b1}}
			: whole[COLOR_W-1:0];
	endfunction

	assign entry      = light_entry_t'(ram_rdata);
	assign accept     = in_ch.valid && in_ch.ready;
	assign dot_pos    = !dot_q[DOT_W-1] && (dot_q != '0);
	assign shade      = dot_pos ? dot_q[FRAC_W+D_W-1:FRAC_W] : '0;
	assign next_num   = light_num_q + CW'(1);
	assign dot_term   = $signed(product[DOT_W-1:0]);
	assign color_term = product[ACC_W-1:0];

	// lights past the table size are not there
	assign eff_count = (32'(cfg.light_count) > MAX_LIGHTS) ? CW'(MAX_LIGHTS)
		: CW'(cfg.light_count);

	// light table write port
	assign ram_we    = accept && (in_ch.func == FUNC_LIGHT_WRITE)
		&& (32'(in_ch.light_slot) < MAX_LIGHTS);
	assign ram_waddr = AW'(in_ch.light_slot);
	assign ram_wdata = {in_ch.vec_x, in_ch.vec_y, in_ch.vec_z,
		in_ch.light_red, in_ch.light_green, in_ch.light_blue};
	assign ram_raddr = light_num_q[AW-1:0];

	// multiplier operands per step
	always_comb begin
		mul_req = '0;
		case (step_q)
			STEP_MUL_X: begin
				mul_req.a = {{(MUL_W-VEC_W){entry.dir_x[VEC_W-1]}}, entry.dir_x};
				mul_req.b = {{(MUL_W-VEC_W){nx_q[VEC_W-1]}}, nx_q};
			end
			STEP_MUL_Y: begin
				mul_req.a = {{(MUL_W-VEC_W){entry.dir_y[VEC_W-1]}}, entry.dir_y};
				mul_req.b = {{(MUL_W-VEC_W){ny_q[VEC_W-1]}}, ny_q};
			end
			STEP_MUL_Z: begin
				mul_req.a = {{(MUL_W-VEC_W){entry.dir_z[VEC_W-1]}}, entry.dir_z};
				mul_req.b = {{(MUL_W-VEC_W){nz_q[VEC_W-1]}}, nz_q};
			end
			STEP_MUL_R: begin
				mul_req.a = {{(MUL_W-D_W){1'b0}}, shade};
				mul_req.b = {{(MUL_W-COLOR_W){1'b0}}, entry.red};
			end
			STEP_MUL_G: begin
				mul_req.a = {{(MUL_W-D_W){1'b0}}, shade};
				mul_req.b = {{(MUL_W-COLOR_W){1'b0}}, entry.green};
			end
			STEP_MUL_B: begin
				mul_req.a = {{(MUL_W-D_W){1'b0}}, shade};
				mul_req.b = {{(MUL_W-COLOR_W){1'b0}}, entry.blue};
			end
			default: begin
				mul_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_MUL_X;
			light_num_q <= '0;
			count_q     <= '0;
			nx_q        <= '0;
			ny_q        <= '0;
			nz_q        <= '0;
			dot_q       <= '0;
			acc_r_q     <= '0;
			acc_g_q     <= '0;
			acc_b_q     <= '0;
			out_valid_q <= 1'b0;
			lit_r_q     <= '0;
			lit_g_q     <= '0;
			lit_b_q     <= '0;
		end else begin
			// the finish step decides the output valid on its own
			if (out_valid_q && out_ch.ready && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (in_ch.func == FUNC_VERTEX)) begin
						nx_q        <= in_ch.vec_x;
						ny_q        <= in_ch.vec_y;
						nz_q        <= in_ch.vec_z;
						light_num_q <= '0;
						count_q     <= eff_count;
						acc_r_q     <= {{(ACC_W-COLOR_W-FRAC_W){1'b0}}, cfg.ambient_red,
							{FRAC_W{1'b0}}};
						acc_g_q     <= {{(ACC_W-COLOR_W-FRAC_W){1'b0}}, cfg.ambient_green,
							{FRAC_W{1'b0}}};
						acc_b_q     <= {{(ACC_W-COLOR_W-FRAC_W){1'b0}}, cfg.ambient_blue,
							{FRAC_W{1'b0}}};
						state_q     <= (eff_count == '0) ? ST_FINISH : ST_LOAD;
					end
				end
				ST_LOAD: begin
					// table read is in flight
					step_q  <= STEP_MUL_X;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					step_q <= step_q + 3'd1;
					case (step_q)
						STEP_MUL_Y: dot_q <= dot_term;
						STEP_MUL_Z: dot_q <= dot_q + dot_term;
						STEP_DOT_END: dot_q <= dot_q + dot_term;
						STEP_MUL_G: acc_r_q <= acc_r_q + color_term;
						STEP_MUL_B: acc_g_q <= acc_g_q + color_term;
						STEP_LAST: begin
							acc_b_q     <= acc_b_q + color_term;
							light_num_q <= next_num;
							state_q     <= (next_num == count_q) ? ST_FINISH : ST_LOAD;
						end
						default: begin
							dot_q <= dot_q;
						end
					endcase
				end
				ST_FINISH: begin
					if (!out_valid_q || out_ch.ready) begin
						lit_r_q     <= clamp_channel(acc_r_q);
						lit_g_q     <= clamp_channel(acc_g_q);
						lit_b_q     <= clamp_channel(acc_b_q);
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ch.ready      = (state_q == ST_IDLE);
	assign out_ch.valid     = out_valid_q;
	assign out_ch.lit_red   = lit_r_q;
	assign out_ch.lit_green = lit_g_q;
	assign out_ch.lit_blue  = lit_b_q;

endmodule

// ----- bench/vertex_directional_lighting_tb.sv -----
// vertex_directional_lighting_tb: self-checking bench for the per-vertex diffuse lighting block
// depends on rtl/vdl_pkg.sv, rtl/vdl_if.sv and the block's rtl
`timescale 1ns / 1ps

module vertex_directional_lighting_tb;
	import vdl_pkg::*;

	localparam int CYCLE_LIMIT    = 1_000_000;
	localparam int TAIL_CYCLES    = 100;
	localparam int WRITE_SETTLE   = 4;     // lets any trailing table write finish
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_REQUESTS = 250;

	typedef struct {
		logic                      func;
		logic signed [VEC_W-1:0]   vec_x;
		logic signed [VEC_W-1:0]   vec_y;
		logic signed [VEC_W-1:0]   vec_z;
		logic [SLOT_W-1:0]         light_slot;
		logic [COLOR_W-1:0]        light_red;
		logic [COLOR_W-1:0]        light_green;
		logic [COLOR_W-1:0]        light_blue;
	} vdl_request_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} lit_color_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	vdl_in_if  in_ch ();
	vdl_out_if out_ch ();

	vertex_directional_lighting u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow of the block: register settings and the light table
	cfg_t         shade_cfg;
	light_entry_t lamp_table [MAX_LIGHTS_DEF];

	// lit colors still owed by the block, oldest first
	lit_color_t expected_colors [$];

	int  mismatch_count;
	int  cycle_count;
	bit  sender_gaps_on;
	bit  sink_stalls_on;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// lambert sum over the active lights, fixed point as the block does it
	function automatic lit_color_t shade_vertex(logic signed [VEC_W-1:0] nx,
			logic signed [VEC_W-1:0] ny, logic signed [VEC_W-1:0] nz);
		longint     acc_r, acc_g, acc_b, dot, shade;
		int         active, i;
		lit_color_t col;
		acc_r  = longint'(shade_cfg.ambient_red) << FRAC_W;
		acc_g  = longint'(shade_cfg.ambient_green) << FRAC_W;
		acc_b  = longint'(shade_cfg.ambient_blue) << FRAC_W;
		// counts above the table size saturate
		active = (shade_cfg.light_count > MAX_LIGHTS_DEF) ? MAX_LIGHTS_DEF
			: int'(shade_cfg.light_count);
		for (i = 0; i < active; i++) begin
			dot = longint'($signed(lamp_table[i].dir_x)) * longint'(nx)
				+ longint'($signed(lamp_table[i].dir_y)) * longint'(ny)
				+ longint'($signed(lamp_table[i].dir_z)) * longint'(nz);
			// back-facing and grazing lights add nothing
			if (dot > 0) begin
				shade = dot >>> FRAC_W;
				acc_r += longint'(lamp_table[i].red) * shade;
				acc_g += longint'(lamp_table[i].green) * shade;
				acc_b += longint'(lamp_table[i].blue) * shade;
			end
		end
		acc_r = acc_r >>> FRAC_W;
		acc_g = acc_g >>> FRAC_W;
		acc_b = acc_b >>> FRAC_W;
		col.red   = (acc_r > 255) ? 8'd255 : COLOR_W'(acc_r);
		col.green = (acc_g > 255) ? 8'd255 : COLOR_W'(acc_g);
		col.blue  = (acc_b > 255) ? 8'd255 : COLOR_W'(acc_b);
		return col;
	endfunction

	// vector component: mostly within unit range, some extremes and raw patterns
	function automatic logic signed [VEC_W-1:0] random_component();
		case ($urandom_range(0, 15))
			0: return VEC_W'($urandom);
			1: begin
				case ($urandom_range(0, 4))
					0: return 16'sh8000;
					1: return 16'sh7fff;
					2: return 16'sd16384;
					3: return -16'sd16384;
					default: return 16'sd0;
				endcase
			end
			default: return VEC_W'(int'($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	function automatic vdl_request_t light_write(logic [SLOT_W-1:0] slot,
			logic signed [VEC_W-1:0] x, logic signed [VEC_W-1:0] y,
			logic signed [VEC_W-1:0] z, logic [COLOR_W-1:0] r,
			logic [COLOR_W-1:0] g, logic [COLOR_W-1:0] b);
		vdl_request_t rq;
		rq.func        = FUNC_LIGHT_WRITE;
		rq.vec_x       = x;
		rq.vec_y       = y;
		rq.vec_z       = z;
		rq.light_slot  = slot;
		rq.light_red   = r;
		rq.light_green = g;
		rq.light_blue  = b;
		return rq;
	endfunction

	// vertex request; the table-write fields are don't-care and get noise
	function automatic vdl_request_t vertex(logic signed [VEC_W-1:0] x,
			logic signed [VEC_W-1:0] y, logic signed [VEC_W-1:0] z);
		vdl_request_t rq;
		rq.func        = FUNC_VERTEX;
		rq.vec_x       = x;
		rq.vec_y       = y;
		rq.vec_z       = z;
		rq.light_slot  = SLOT_W'($urandom);
		rq.light_red   = COLOR_W'($urandom);
		rq.light_green = COLOR_W'($urandom);
		rq.light_blue  = COLOR_W'($urandom);
		return rq;
	endfunction

	// one request on in_ch; called and returns just after a falling edge
	task automatic send_request(input vdl_request_t rq);
		if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.func        <= rq.func;
		in_ch.vec_x       <= rq.vec_x;
		in_ch.vec_y       <= rq.vec_y;
		in_ch.vec_z       <= rq.vec_z;
		in_ch.light_slot  <= rq.light_slot;
		in_ch.light_red   <= rq.light_red;
		in_ch.light_green <= rq.light_green;
		in_ch.light_blue  <= rq.light_blue;
		do @(posedge clk); while (!in_ch.ready);
		// accepted at this edge: update the shadow or queue the lit color
		if (rq.func == FUNC_LIGHT_WRITE) begin
			lamp_table[rq.light_slot].dir_x = rq.vec_x;
			lamp_table[rq.light_slot].dir_y = rq.vec_y;
			lamp_table[rq.light_slot].dir_z = rq.vec_z;
			lamp_table[rq.light_slot].red   = rq.light_red;
			lamp_table[rq.light_slot].green = rq.light_green;
			lamp_table[rq.light_slot].blue  = rq.light_blue;
		end else begin
			expected_colors.push_back(shade_vertex(rq.vec_x, rq.vec_y, rq.vec_z));
		end
		@(negedge clk);
	endtask

	// stop sending until every lit color has come back
	task automatic hold_until_drained();
		in_ch.valid <= 1'b0;
		do @(negedge clk); while (expected_colors.size() != 0);
	endtask

	// block idle: nothing owed and any trailing table write finished
	task automatic wait_idle();
		hold_until_drained();
		repeat (WRITE_SETTLE) @(negedge clk);
	endtask

	// apb write: setup then access, register taken at the edge with pready
	task automatic write_register(input logic [REG_IDX_W-1:0] idx,
			input logic [APB_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_LIGHT_COUNT:   shade_cfg.light_count   = value[COUNT_W-1:0];
			REG_AMBIENT_RED:   shade_cfg.ambient_red   = value[COLOR_W-1:0];
			REG_AMBIENT_GREEN: shade_cfg.ambient_green = value[COLOR_W-1:0];
			REG_AMBIENT_BLUE:  shade_cfg.ambient_blue  = value[COLOR_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_lighting(input int count, input int r, input int g, input int b);
		write_register(REG_LIGHT_COUNT, count);
		write_register(REG_AMBIENT_RED, r);
		write_register(REG_AMBIENT_GREEN, g);
		write_register(REG_AMBIENT_BLUE, b);
	endtask

	// no lights in use: output is the ambient level, table never read
	task automatic test_ambient_only();
		set_lighting(0, 255, 0, 1);
		send_request(vertex(16'sh7fff, 16'sh8000, 16'sd0));
		send_request(vertex(16'sd0, 16'sd0, 16'sd0));
		wait_idle();
	endtask

	// fill every table entry with extreme directions and colors
	task automatic test_light_table();
		send_request(light_write(0, 16'sd16384, 16'sd0, 16'sd0, 8'd255, 8'd255, 8'd255));
		send_request(light_write(1, -16'sd16384, 16'sd0, 16'sd0, 8'd0, 8'd0, 8'd0));
		send_request(light_write(2, 16'sd0, 16'sd16384, 16'sd0, 8'd255, 8'd0, 8'd0));
		send_request(light_write(3, 16'sd0, -16'sd16384, 16'sd0, 8'd0, 8'd255, 8'd0));
		send_request(light_write(4, 16'sd0, 16'sd0, 16'sd16384, 8'd0, 8'd0, 8'd255));
		send_request(light_write(5, 16'sd0, 16'sd0, -16'sd16384, 8'd17, 8'd34, 8'd51));
		send_request(light_write(6, 16'sh8000, 16'sh8000, 16'sh8000, 8'd255, 8'd128, 8'd1));
		send_request(light_write(7, 16'sh7fff, 16'sh7fff, 16'sh7fff, 8'd1, 8'd2, 8'd3));
		wait_idle();
	endtask

	// all eight lights: facing, back-facing, orthogonal and overflowing normals
	task automatic test_vertex_directions();
		set_lighting(MAX_LIGHTS_DEF, 0, 0, 0);
		send_request(vertex(16'sd16384, 16'sd0, 16'sd0));
		send_request(vertex(-16'sd16384, 16'sd0, 16'sd0));
		send_request(vertex(16'sd0, 16'sd16384, 16'sd0));
		send_request(vertex(16'sd0, 16'sd0, -16'sd16384));
		send_request(vertex(16'sd0, 16'sd0, 16'sd0));
		send_request(vertex(16'sh8000, 16'sh8000, 16'sh8000));
		send_request(vertex(16'sh7fff, 16'sh7fff, 16'sh7fff));
		send_request(vertex(16'sd1, -16'sd1, 16'sd0));
		wait_idle();
	endtask

	// oversized light count saturates; tiny dot products truncate to nothing
	task automatic test_count_and_truncation();
		send_request(light_write(0, 16'sd1, 16'sd0, 16'sd0, 8'd255, 8'd255, 8'd255));
		wait_idle();
		set_lighting(15, 200, 0, 255);
		send_request(vertex(16'sd16384, 16'sd0, 16'sd0));
		wait_idle();
		set_lighting(1, 0, 0, 0);
		send_request(vertex(16'sd16383, 16'sd0, 16'sd0));
		send_request(vertex(16'sd16384, 16'sd0, 16'sd0));
		wait_idle();
	endtask

	// sender holds back until the block has handed over every color
	task automatic test_drain_pause();
		int k;
		set_lighting(MAX_LIGHTS_DEF, 10, 20, 30);
		for (k = 0; k < 12; k++) begin
			send_request(vertex(random_component(), random_component(), random_component()));
			if (k % 4 == 3)
				hold_until_drained();
		end
		wait_idle();
	endtask

	// phases of random traffic, each under its own register settings
	task automatic test_random_traffic();
		int phase, k, count;
		int amb_r, amb_g, amb_b;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin count = MAX_LIGHTS_DEF; amb_r = 255; amb_g = 255; amb_b = 255; end
				1: begin count = 0; amb_r = 0; amb_g = 0; amb_b = 0; end
				2: begin count = 15; amb_r = 0; amb_g = 255; amb_b = 0; end
				default: begin
					count = $urandom_range(0, 15);
					amb_r = $urandom_range(0, 255);
					amb_g = $urandom_range(0, 255);
					amb_b = $urandom_range(0, 255);
				end
			endcase
			set_lighting(count, amb_r, amb_g, amb_b);
			for (k = 0; k < PHASE_REQUESTS; k++) begin
				// idling comes and goes; the last phases run flat out
				if (k % 50 == 0) begin
					sender_gaps_on = (phase < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
					sink_stalls_on = (phase < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
				end
				// every table entry is written already, so any slot may be rewritten
				if ($urandom_range(0, 3) == 0)
					send_request(light_write(SLOT_W'($urandom), random_component(),
						random_component(), random_component(), COLOR_W'($urandom),
						COLOR_W'($urandom), COLOR_W'($urandom)));
				else
					send_request(vertex(random_component(), random_component(),
						random_component()));
				if ($urandom_range(0, 59) == 0)
					hold_until_drained();
			end
			wait_idle();
		end
	endtask

	// result side: random ready stalls, driven on the falling edge
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_stalls_on && $urandom_range(0, 7) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	// compare each lit color with the oldest one owed
	always @(posedge clk) begin
		lit_color_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_colors.size() == 0) begin
				$error("lit color %0d/%0d/%0d with no vertex request outstanding",
					out_ch.lit_red, out_ch.lit_green, out_ch.lit_blue);
				mismatch_count++;
			end else begin
				want = expected_colors.pop_front();
				if (out_ch.lit_red !== want.red) begin
					$error("lit_red: expected %0d, got %0d", want.red, out_ch.lit_red);
					mismatch_count++;
				end
				if (out_ch.lit_green !== want.green) begin
					$error("lit_green: expected %0d, got %0d", want.green, out_ch.lit_green);
					mismatch_count++;
				end
				if (out_ch.lit_blue !== want.blue) begin
					$error("lit_blue: expected %0d, got %0d", want.blue, out_ch.lit_blue);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		in_ch.valid       = 1'b0;
		in_ch.func        = FUNC_VERTEX;
		in_ch.vec_x       = '0;
		in_ch.vec_y       = '0;
		in_ch.vec_z       = '0;
		in_ch.light_slot  = '0;
		in_ch.light_red   = '0;
		in_ch.light_green = '0;
		in_ch.light_blue  = '0;
		shade_cfg         = '0;
		mismatch_count    = 0;
		cycle_count       = 0;
		sender_gaps_on    = 1'b1;
		sink_stalls_on    = 1'b1;
		// the shadow table starts at zero until written
		foreach (lamp_table[i])
			lamp_table[i] = '0;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_ambient_only();
		test_light_table();
		test_vertex_directions();
		test_count_and_truncation();
		test_drain_pause();
		test_random_traffic();

		hold_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_colors.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
